>>> src/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// Holds the descriptor layout and the controller-to-datapath command/status structs.
package ffba_pkg;

  localparam int MEM_WORDS  = 65536;
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam logic [15:0] TOP_ADDR = 16'(MEM_WORDS - 1);
  localparam logic [15:0] ADDR_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE_ADDR  = 2'd1,
    OP_FREE_OWNER = 2'd2,
    OP_NOP        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BADPTR   = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] size;
    logic [7:0]  owner;
  } entry_t;

  typedef enum logic [2:0] {RD_I, RD_IM1, RD_IP1, RD_JM1, RD_JP1} rd_sel_t;
  typedef enum logic [2:0] {WD_OWN, WD_SHIFT, WD_REST, WD_SPLIT, WD_EXT, WD_CUR} wr_sel_t;
  typedef enum logic [2:0] {CUR_HOLD, CUR_LOAD, CUR_LOAD_FREE, CUR_MERGE_UP,
                            CUR_MERGE_DN} cur_op_t;
  typedef enum logic [1:0] {I_HOLD, I_CLR, I_INC, I_DEC} i_op_t;
  typedef enum logic [2:0] {J_HOLD, J_COUNT, J_I, J_I1, J_DEC, J_INC} j_op_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic [1:0] {HL_HOLD, HL_EXT, HL_RD, HL_TOP} hl_op_t;
  typedef enum logic [1:0] {WH_ZERO, WH_RD, WH_SPLIT, WH_EXT} where_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    cur_op_t cur_op;
    i_op_t   i_op;
    j_op_t   j_op;
    cnt_op_t cnt_op;
    hl_op_t  hl_op;
    logic    res_we;
    status_t res_st;
    where_t  res_where;
  } cmd_t;

  typedef struct packed {
    logic by_addr;
    op_t  op;
    logic i_eq_cnt;
    logic i_zero;
    logic i1_lt_cnt;
    logic i1_eq_cnt;
    logic j_gt_i1;
    logic j1_lt_cnt;
    logic cnt_full;
    logic fit;
    logic exact;
    logic hit;
    logic up_ok;
    logic dn_ok;
    logic ext_ok;
  } stat_t;

endpackage

>>> src/ffba_dp.sv
// Datapath: descriptor memory, scan/shift indexes, working entry and result registers.
// Depends on ffba_pkg.
module ffba_dp (
  input  logic               clk,
  input  logic               rst,
  input  ffba_pkg::cmd_t     cmd,
  input  logic [1:0]         opcode,
  input  logic [7:0]         owner,
  input  logic [15:0]        size,
  input  logic [15:0]        address,
  input  logic [15:0]        limit,
  input  logic [15:0]        stack_limit,
  output ffba_pkg::stat_t    stat,
  output logic [15:0]        block_address,
  output logic [1:0]         status,
  output logic [15:0]        heap_bottom
);
  import ffba_pkg::*;

  entry_t mem [MAX_BLOCKS];
  entry_t rdata;
  entry_t cur;
  entry_t wdata;

  op_t         op;
  logic        by_addr;
  logic [7:0]  who;
  logic [15:0] want;
  logic [15:0] ptr;
  logic [15:0] lim;
  logic [15:0] stk;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] count;
  logic [15:0] heap_low;
  logic [15:0] res_addr;
  status_t     res_st;

  logic [CNT_W-1:0] i1;
  logic [CNT_W-1:0] j1;
  logic [CNT_W-1:0] raddr;
  logic [CNT_W-1:0] waddr;
  logic [15:0] split_addr;
  logic [15:0] ext_addr;
  logic [15:0] where;
  logic signed [17:0] gap;
  logic [7:0]  who_free;
  logic        match;

  assign i1 = i + CNT_W'(1);
  assign j1 = j + CNT_W'(1);
  assign split_addr = cur.addr + cur.size - want;
  assign ext_addr   = heap_low - want;
  assign gap = $signed({2'b00, heap_low}) - $signed({2'b00, stk});
  assign who_free = by_addr ? 8'd0 : who;
  assign match = by_addr ? (rdata.addr == ptr) : (rdata.owner == who);

  always_comb begin
    stat.by_addr   = by_addr;
    stat.op        = op;
    stat.i_eq_cnt  = (i == count);
    stat.i_zero    = (i == '0);
    stat.i1_lt_cnt = (i1 < count);
    stat.i1_eq_cnt = (i1 == count);
    stat.j_gt_i1   = (j > i1);
    stat.j1_lt_cnt = (j1 < count);
    stat.cnt_full  = (count == CNT_W'(MAX_BLOCKS));
    stat.fit       = (rdata.owner == 8'd0) && (rdata.size >= want);
    stat.exact     = (rdata.size == want);
    stat.hit       = (rdata.addr <= lim) && (rdata.owner != 8'd0) && match;
    stat.up_ok     = (rdata.addr <= lim) &&
                     ((rdata.owner == 8'd0) || (rdata.owner == who_free));
    stat.dn_ok     = (rdata.owner == 8'd0) || (rdata.owner == who_free);
    stat.ext_ok    = gap > $signed({2'b00, want});
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_IM1:  raddr = i - CNT_W'(1);
      RD_IP1:  raddr = i1;
      RD_JM1:  raddr = j - CNT_W'(1);
      RD_JP1:  raddr = j1;
      default: raddr = i;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WD_OWN: begin
        waddr = i;
        wdata = '{addr: rdata.addr, size: rdata.size, owner: who};
      end
      WD_SHIFT: begin
        waddr = j;
        wdata = rdata;
      end
      WD_REST: begin
        waddr = i1;
        wdata = '{addr: cur.addr, size: cur.size - want, owner: 8'd0};
      end
      WD_SPLIT: begin
        waddr = i;
        wdata = '{addr: split_addr, size: want, owner: who};
      end
      WD_EXT: begin
        waddr = count;
        wdata = '{addr: ext_addr, size: want, owner: who};
      end
      default: begin
        waddr = i;
        wdata = cur;
      end
    endcase
  end

  always_comb begin
    case (cmd.res_where)
      WH_RD:    where = rdata.addr;
      WH_SPLIT: where = split_addr;
      WH_EXT:   where = ext_addr;
      default:  where = 16'd0;
    endcase
  end

  // descriptor store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr[IDX_W-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= op_t'(opcode);
      by_addr <= (op_t'(opcode) == OP_FREE_ADDR);
      who     <= (op_t'(opcode) == OP_FREE_ADDR) ? 8'd0 : owner;
      want    <= (size == 16'd0) ? 16'd1 : size;
      ptr     <= address;
      lim     <= (op_t'(opcode) == OP_FREE_ADDR) ? ADDR_MAX : limit;
      stk     <= stack_limit;
    end
    case (cmd.cur_op)
      CUR_LOAD:      cur <= rdata;
      CUR_LOAD_FREE: cur <= '{addr: rdata.addr, size: rdata.size, owner: 8'd0};
      CUR_MERGE_UP:  cur <= '{addr: cur.addr, size: rdata.size + cur.size,
                              owner: rdata.owner};
      CUR_MERGE_DN:  cur <= '{addr: rdata.addr, size: cur.size + rdata.size,
                              owner: cur.owner};
      default:       cur <= cur;
    endcase
    case (cmd.i_op)
      I_CLR:   i <= '0;
      I_INC:   i <= i1;
      I_DEC:   i <= i - CNT_W'(1);
      default: i <= i;
    endcase
    case (cmd.j_op)
      J_COUNT: j <= count;
      J_I:     j <= i;
      J_I1:    j <= i1;
      J_DEC:   j <= j - CNT_W'(1);
      J_INC:   j <= j1;
      default: j <= j;
    endcase
    if (cmd.res_we) begin
      res_addr <= where;
      res_st   <= cmd.res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      heap_low <= TOP_ADDR;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
      case (cmd.hl_op)
        HL_EXT:  heap_low <= ext_addr;
        HL_RD:   heap_low <= rdata.addr;
        HL_TOP:  heap_low <= TOP_ADDR;
        default: heap_low <= heap_low;
      endcase
    end
  end

  assign block_address = res_addr;
  assign status        = res_st;
  assign heap_bottom   = heap_low;

endmodule

>>> src/ffba_ctrl.sv
// Controller: sequences scans, table shifts, merges and result strobes.
// Depends on ffba_pkg; drives ffba_dp through cmd_t.
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      opcode,
  input  ffba_pkg::stat_t stat,
  output ffba_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import ffba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_SH, S_A_SHW, S_A_FILL1, S_A_FILL2, S_A_EXT,
    S_F_RD, S_F_CHK, S_F_UP, S_F_DN, S_F_DN2, S_F_WB, S_F_LOW, S_DROP, S_DROPW
  } state_t;

  state_t state, state_next, ret, ret_next;
  logic   finish;

  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.i_op = I_CLR;
          unique case (op_t'(opcode)) inside
            OP_ALLOC:                    state_next = S_A_RD;
            OP_FREE_ADDR, OP_FREE_OWNER: state_next = S_F_RD;
            default: begin
              cmd.res_we = 1'b1;
              finish     = 1'b1;
            end
          endcase
        end
      end
      S_A_RD: begin
        if (stat.i_eq_cnt) begin
          state_next = S_A_EXT;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (!stat.fit) begin
          cmd.i_op   = I_INC;
          state_next = S_A_RD;
        end else if (stat.exact) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WD_OWN;
          cmd.res_we    = 1'b1;
          cmd.res_where = WH_RD;
          finish        = 1'b1;
          state_next    = S_IDLE;
        end else if (stat.cnt_full) begin
          cmd.res_we = 1'b1;
          cmd.res_st = ST_OVERFLOW;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.cur_op = CUR_LOAD;
          cmd.j_op   = J_COUNT;
          state_next = S_A_SH;
        end
      end
      S_A_SH: begin
        if (stat.j_gt_i1) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_JM1;
          state_next = S_A_SHW;
        end else begin
          state_next = S_A_FILL1;
        end
      end
      S_A_SHW: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_SHIFT;
        cmd.j_op   = J_DEC;
        state_next = S_A_SH;
      end
      S_A_FILL1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_REST;
        state_next = S_A_FILL2;
      end
      S_A_FILL2: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WD_SPLIT;
        cmd.cnt_op    = CNT_INC;
        cmd.res_we    = 1'b1;
        cmd.res_where = WH_SPLIT;
        finish        = 1'b1;
        state_next    = S_IDLE;
      end
      S_A_EXT: begin
        cmd.res_we = 1'b1;
        finish     = 1'b1;
        state_next = S_IDLE;
        if (stat.ext_ok && !stat.cnt_full) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WD_EXT;
          cmd.cnt_op    = CNT_INC;
          cmd.hl_op     = HL_EXT;
          cmd.res_where = WH_EXT;
        end else begin
          cmd.res_st = ST_OVERFLOW;
        end
      end
      S_F_RD: begin
        if (stat.i_eq_cnt) begin
          cmd.res_we = 1'b1;
          cmd.res_st = stat.by_addr ? ST_BADPTR : ST_OK;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (stat.hit) begin
          cmd.cur_op = CUR_LOAD_FREE;
          if (stat.i_zero) begin
            state_next = S_F_DN;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IM1;
            state_next = S_F_UP;
          end
        end else begin
          cmd.i_op   = I_INC;
          state_next = S_F_RD;
        end
      end
      S_F_UP: begin
        if (stat.up_ok) begin
          // fold into the block above; old slot is squeezed out
          cmd.cur_op = CUR_MERGE_UP;
          cmd.j_op   = J_I;
          cmd.i_op   = I_DEC;
          ret_next   = S_F_DN;
          state_next = S_DROP;
        end else begin
          state_next = S_F_DN;
        end
      end
      S_F_DN: begin
        if (stat.i1_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IP1;
          state_next = S_F_DN2;
        end else begin
          state_next = S_F_WB;
        end
      end
      S_F_DN2: begin
        if (stat.dn_ok) begin
          cmd.cur_op = CUR_MERGE_DN;
          cmd.j_op   = J_I1;
          ret_next   = S_F_WB;
          state_next = S_DROP;
        end else begin
          state_next = S_F_WB;
        end
      end
      S_F_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_CUR;
        if (stat.i1_eq_cnt) begin
          // lowest block goes away and the heap bottom rises
          if (stat.i_zero) begin
            cmd.hl_op  = HL_TOP;
            cmd.cnt_op = CNT_DEC;
            cmd.res_we = 1'b1;
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IM1;
            state_next = S_F_LOW;
          end
        end else if (stat.by_addr) begin
          cmd.res_we = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_F_RD;
        end
      end
      S_F_LOW: begin
        cmd.hl_op  = HL_RD;
        cmd.cnt_op = CNT_DEC;
        cmd.res_we = 1'b1;
        finish     = 1'b1;
        state_next = S_IDLE;
      end
      S_DROP: begin
        if (stat.j1_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_JP1;
          state_next = S_DROPW;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = ret;
        end
      end
      S_DROPW: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_SHIFT;
        cmd.j_op   = J_INC;
        state_next = S_DROP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_F_WB;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      done  <= finish;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

>>> src/first_fit_block_allocator.sv
// First-fit downward-growing heap allocator, top level.
// Each descriptor scanned is read and then checked; each descriptor moved to open or close a
// slot is read and then written back. Worst case is a free by owner that merges a long run.
// One item at a time, next one taken in the done cycle; done pulses for one cycle, no stall
// possible. Sync reset: empty table, bottom at top.
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  opcode,
  input  logic [7:0]  owner,
  input  logic [15:0] size,
  input  logic [15:0] address,
  input  logic [15:0] limit,
  input  logic [15:0] stack_limit,
  output logic [15:0] block_address,
  output logic [1:0]  status,
  output logic [15:0] heap_bottom
);
  import ffba_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the state machine and the done strobe
  ffba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // datapath: descriptor memory, indexes, heap bottom, result registers
  ffba_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .owner         (owner),
    .size          (size),
    .address       (address),
    .limit         (limit),
    .stack_limit   (stack_limit),
    .stat          (stat),
    .block_address (block_address),
    .status        (status),
    .heap_bottom   (heap_bottom)
  );

endmodule
